>>> src/tdq_pkg.sv
// Package for the timed two-priority dispatch queue.
// Holds payload structs, operation/status codes, the timer cell entry type and FSM states.
// No dependencies.
package tdq_pkg;

  localparam int IDX_W = 8;  // covers up to 256 timer cells

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_TICK  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NONE   = 2'd1,
    STS_FFULL  = 2'd2,
    STS_TFULL  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] tag;
    logic        priority_req;
    logic [15:0] delay;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ready_tag;
    logic        ready_priority;
    logic        next_due_valid;
    logic [31:0] next_due_time;
  } rsp_t;

  // Timer entry, also the candidate that travels down the cell chain.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [31:0]      due;
    logic [31:0]      seq;
    logic [15:0]      tag;
    logic             prio;
  } cand_t;

  typedef struct packed {
    logic             load;
    logic             clear_all;
    logic             drop;
    logic [IDX_W-1:0] drop_idx;
  } cell_ctl_t;

endpackage

>>> src/tdq_cell.sv
// One timer cell: holds one timed entry and forwards the earlier of its own
// entry and the incoming candidate, registered. Depends on tdq_pkg.
module tdq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tdq_pkg::IDX_W-1:0] cell_index,
  input  logic [31:0]               now,
  input  tdq_pkg::cell_ctl_t        ctl,
  input  tdq_pkg::cand_t            load_data,
  input  tdq_pkg::cand_t            cand_in,
  output tdq_pkg::cand_t            cand_out,
  output logic                      valid
);
  import tdq_pkg::*;

  cand_t       entry;
  cand_t       own;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] seq_diff;
  logic        own_first;

  always_comb begin
    own       = entry;
    own.valid = valid;
    own.idx   = cell_index;
    ka        = (entry.due - now) ^ 32'h8000_0000;
    kb        = (cand_in.due - now) ^ 32'h8000_0000;
    seq_diff  = entry.seq - cand_in.seq;
    if (!valid) begin
      own_first = 1'b0;
    end else if (!cand_in.valid) begin
      own_first = 1'b1;
    end else if (ka != kb) begin
      own_first = ka < kb;
    end else begin
      own_first = seq_diff[31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      cand_out <= '0;
    end else begin
      cand_out <= own_first ? own : cand_in;
      if (ctl.clear_all || (ctl.drop && ctl.drop_idx == cell_index)) begin
        valid <= 1'b0;
      end else if (ctl.load) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= load_data;
    end
  end

endmodule

>>> src/tdq_fifo.sv
// Tag FIFO with registered read of the head entry.
// Depends on nothing beyond its DEPTH parameter.
module tdq_fifo #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [15:0] push_tag,
  input  logic        pop,
  input  logic        clear,
  output logic        full,
  output logic        nonempty,
  output logic [15:0] head_tag
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0]   mem [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;

  assign full     = count == CW'(DEPTH);
  assign nonempty = count != '0;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= wrap_inc(tail);
      if (pop)  head <= wrap_inc(head);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[tail] <= push_tag;
    head_tag <= mem[head];
  end

endmodule

>>> src/timed_two_priority_dispatch_queue.sv
// Timed two-priority dispatch queue: one command in, one result out.
// Push, tick, clear and unknown codes finish in the idle state. Pop and peek scan
// the timer chain once, and once more for each timed item promoted, the candidate
// traveling one timer cell per cycle down the chain.
// Throughput: one command at a time; the next is taken the cycle after the result transfers.
// Reset (rst, synchronous): FIFOs empty, timer cells invalid, time and sequence zero.
module timed_two_priority_dispatch_queue #(
  parameter int FIFO_DEPTH  = 16,
  parameter int TIMED_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  tdq_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tdq_pkg::rsp_t  rsp
);
  import tdq_pkg::*;

  localparam int CNT_W = $clog2(TIMED_DEPTH + 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             is_peek;
  logic [31:0]      now;
  logic [31:0]      seq_ctr;

  logic             accept;
  logic             done;
  rsp_t             res;

  // FIFO controls
  logic        nf_push, if_push, nf_pop, if_pop, fifo_clr;
  logic [15:0] push_tag;
  logic        nf_full, if_full, nf_ne, if_ne;
  logic [15:0] nf_tag, if_tag;

  // Timer chain
  cand_t                  chain [TIMED_DEPTH+1];
  logic [TIMED_DEPTH-1:0] cell_valid;
  logic [TIMED_DEPTH-1:0] free_oh;
  logic                   free_any;
  logic                   load_en, clr_all, promote_clr, now_inc, seq_inc;
  cand_t                  load_data;
  cand_t                  tail;
  logic [31:0]            lag;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE) || rsp_valid;
  assign chain[0]  = '0;
  assign tail      = chain[TIMED_DEPTH];
  assign lag       = now - tail.due;

  tdq_fifo #(.DEPTH(FIFO_DEPTH)) u_normal (
    .clk, .rst, .push(nf_push), .push_tag, .pop(nf_pop), .clear(fifo_clr),
    .full(nf_full), .nonempty(nf_ne), .head_tag(nf_tag)
  );

  tdq_fifo #(.DEPTH(FIFO_DEPTH)) u_idle (
    .clk, .rst, .push(if_push), .push_tag, .pop(if_pop), .clear(fifo_clr),
    .full(if_full), .nonempty(if_ne), .head_tag(if_tag)
  );

  // Lowest free timer cell takes a delayed push.
  always_comb begin
    free_oh  = '0;
    free_any = 1'b0;
    for (int i = 0; i < TIMED_DEPTH; i++) begin
      if (!cell_valid[i] && !free_any) begin
        free_oh[i] = 1'b1;
        free_any   = 1'b1;
      end
    end
  end

  always_comb begin
    load_data       = '0;
    load_data.valid = 1'b1;
    load_data.due   = now + 32'(req.delay);
    load_data.seq   = seq_ctr;
    load_data.tag   = req.tag;
    load_data.prio  = req.priority_req;
  end

  for (genvar g = 0; g < TIMED_DEPTH; g++) begin : g_cell
    cell_ctl_t ctl;
    always_comb begin
      ctl.load      = load_en && free_oh[g];
      ctl.clear_all = clr_all;
      ctl.drop      = promote_clr;
      ctl.drop_idx  = tail.idx;
    end
    tdq_cell u_cell (
      .clk, .rst,
      .cell_index(IDX_W'(g)),
      .now,
      .ctl,
      .load_data,
      .cand_in(chain[g]),
      .cand_out(chain[g+1]),
      .valid(cell_valid[g])
    );
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    nf_push     = 1'b0;
    if_push     = 1'b0;
    nf_pop      = 1'b0;
    if_pop      = 1'b0;
    fifo_clr    = 1'b0;
    push_tag    = req.tag;
    load_en     = 1'b0;
    clr_all     = 1'b0;
    promote_clr = 1'b0;
    now_inc     = 1'b0;
    seq_inc     = 1'b0;
    done        = 1'b0;
    res         = '0;
    res.status  = STS_OK;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(req.operation))
            OP_PUSH: begin
              done = 1'b1;
              if (req.delay == '0) begin
                if (req.priority_req) begin
                  if (nf_full) res.status = STS_FFULL;
                  else nf_push = 1'b1;
                end else begin
                  if (if_full) res.status = STS_FFULL;
                  else if_push = 1'b1;
                end
              end else if (free_any) begin
                load_en = 1'b1;
                seq_inc = 1'b1;
              end else begin
                res.status = STS_TFULL;
              end
            end
            OP_POP, OP_PEEK: begin
              state_next = ST_SCAN;
              cnt_next   = '0;
            end
            OP_TICK: begin
              now_inc = 1'b1;
              done    = 1'b1;
            end
            OP_CLEAR: begin
              fifo_clr = 1'b1;
              clr_all  = 1'b1;
              done     = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt != CNT_W'(TIMED_DEPTH)) begin
          // hold until the candidate has crossed every cell
          cnt_next = cnt + 1'b1;
        end else if (tail.valid && !lag[31] && !(tail.prio ? nf_full : if_full)) begin
          // promote the earliest due item, then rescan
          push_tag    = tail.tag;
          nf_push     = tail.prio;
          if_push     = !tail.prio;
          promote_clr = 1'b1;
          cnt_next    = '0;
        end else begin
          done       = 1'b1;
          state_next = ST_IDLE;
          if (nf_ne) begin
            res.ready_tag      = nf_tag;
            res.ready_priority = 1'b1;
            nf_pop             = !is_peek;
          end else if (if_ne) begin
            res.ready_tag = if_tag;
            if_pop        = !is_peek;
          end else begin
            res.status = STS_NONE;
          end
          if (is_peek && tail.valid) begin
            res.next_due_valid = 1'b1;
            res.next_due_time  = tail.due;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      is_peek   <= 1'b0;
      now       <= '0;
      seq_ctr   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) is_peek <= req.operation == OP_PEEK;
      if (now_inc) now <= now + 1'b1;
      if (seq_inc) seq_ctr <= seq_ctr + 1'b1;
      if (done) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) rsp <= res;
  end

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_CLEAR) |=> (cell_valid == '0))
    else $error("timer cells still valid after clear");

  a_none_zero_tag: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STS_NONE) |-> (rsp.ready_tag == '0 && !rsp.ready_priority))
    else $error("empty result carries a tag");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= CNT_W'(TIMED_DEPTH)))
    else $error("scan counter overran the chain");

  a_promote_due: assert property (@(posedge clk) disable iff (rst)
    promote_clr |-> (tail.valid && !lag[31]))
    else $error("promoted an item that is not due");
`endif

endmodule
